>>> rtl/two_line_intersection_top_macros.svh
// Assertion macros for the checker file of the intersection block.
`ifndef TWO_LINE_INTERSECTION_TOP_MACROS_SVH
`define TWO_LINE_INTERSECTION_TOP_MACROS_SVH

// Check a property with reset masking it.
`define TLI_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included.
`define TLI_CHECK_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/tli_pkg.sv
// Types, codes and helper functions shared by the intersection block.
`timescale 1ns / 1ps
package tli_pkg;

   localparam int WORD_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type b;
      word_type c;
      logic     has_y;
   } line_coef_type;

   localparam logic [1:0] ST_PARALLEL = 2'd0;
   localparam logic [1:0] ST_POINT    = 2'd1;
   localparam logic [1:0] ST_SAME     = 2'd2;

   localparam logic [15:0] TOL_RESET = 16'd1;
   localparam word_type    COEF_MAX  = 32'sh7FFF_FFFF;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      logic [32:0] m;
      m = v[32] ? 33'(-v) : 33'(v);
      return m;
   endfunction

   // Apply sign and saturate; sym limits a negative result to -(2^31 - 1).
   function automatic word_type sat_word(input logic [WORD_W-1:0] q, input logic ovf,
                                         input logic neg, input logic sym);
      logic [WORD_W-1:0] lim;
      logic [WORD_W-1:0] m;
      lim = (neg && !sym) ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      m = (ovf || (q > lim)) ? lim : q;
      return neg ? word_type'(-m) : word_type'(m);
   endfunction

endpackage

>>> rtl/tli_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`timescale 1ns / 1ps
module tli_div #(
   parameter int NW = 49,
   parameter int DW = 33,
   parameter int QW = 32,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic          out_ovf,
   output logic [TW-1:0] out_tag
);

   localparam int CW = NW + DW + QW;

   logic          valid_ff [0:QW];
   logic [DW-1:0] rem_ff   [0:QW];
   logic [DW-1:0] den_ff   [0:QW];
   logic [QW-1:0] lo_ff    [0:QW];
   logic [QW-1:0] quo_ff   [0:QW];
   logic          ovf_ff   [0:QW];
   logic [TW-1:0] tag_ff   [0:QW];

   logic [CW-1:0] wide_num;
   logic [CW-1:0] wide_den;
   logic [CW-1:0] wide_top;
   logic          ovf_in;

   always_comb begin
      wide_num = CW'(in_num);
      wide_den = CW'(in_den) << QW;
      wide_top = wide_num >> QW;
      ovf_in   = wide_num >= wide_den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0] <= wide_top[DW-1:0];
      den_ff[0] <= in_den;
      lo_ff[0]  <= in_num[QW-1:0];
      quo_ff[0] <= '0;
      ovf_ff[0] <= ovf_in;
      tag_ff[0] <= in_tag;
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int BIT = QW - 1 - k;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      always_comb begin
         trial       = {rem_ff[k], lo_ff[k][BIT]};
         diff        = trial - {1'b0, den_ff[k]};
         ge          = trial >= {1'b0, den_ff[k]};
         rem_in      = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in      = quo_ff[k];
         quo_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= den_ff[k];
         lo_ff[k+1]  <= lo_ff[k];
         quo_ff[k+1] <= quo_in;
         ovf_ff[k+1] <= ovf_ff[k];
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_ovf   = ovf_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

>>> rtl/tli_line.sv
// Coefficient pipeline: turns two points into slope and offset of one line.
`timescale 1ns / 1ps
module tli_line #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tli_pkg::word_type      in_x1,
   input  tli_pkg::word_type      in_y1,
   input  tli_pkg::word_type      in_x2,
   input  tli_pkg::word_type      in_y2,
   input  logic [15:0]            tol,
   output logic                   out_valid,
   output tli_pkg::line_coef_type out_coef
);

   localparam int NW = 33 + FRAC_BITS;
   localparam tli_pkg::word_type ONE_Q = tli_pkg::word_type'(64'sd1 << FRAC_BITS);

   typedef struct packed {
      logic              vert;
      logic              neg;
      tli_pkg::word_type x1;
      tli_pkg::word_type x2;
      tli_pkg::word_type y2;
   } ltag_type;

   function automatic tli_pkg::word_type clamp_coef(input logic signed [63:0] v);
      tli_pkg::word_type r;
      if (v > 64'(tli_pkg::COEF_MAX)) begin
         r = tli_pkg::COEF_MAX;
      end else if (v < -64'(tli_pkg::COEF_MAX)) begin
         r = -tli_pkg::COEF_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic                v0_ff;
   logic signed [32:0]  dx_ff, dy_ff;
   tli_pkg::word_type   x1_ff, x2_ff, y2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      dx_ff <= 33'(in_x1) - 33'(in_x2);
      dy_ff <= 33'(in_y2) - 33'(in_y1);
      x1_ff <= in_x1;
      x2_ff <= in_x2;
      y2_ff <= in_y2;
   end

   logic          v1_ff;
   logic [NW-1:0] num_ff;
   logic [32:0]   den_ff;
   ltag_type      tag1_ff;
   logic [32:0]   dx_mag, dy_mag;

   always_comb begin
      dx_mag = tli_pkg::mag33(dx_ff);
      dy_mag = tli_pkg::mag33(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      num_ff       <= NW'(dy_mag) << FRAC_BITS;
      den_ff       <= dx_mag;
      tag1_ff.vert <= dx_mag <= 33'(tol);
      tag1_ff.neg  <= dx_ff[32] ^ dy_ff[32];
      tag1_ff.x1   <= x1_ff;
      tag1_ff.x2   <= x2_ff;
      tag1_ff.y2   <= y2_ff;
   end

   logic        dv_valid;
   logic [31:0] dv_quo;
   logic        dv_ovf;
   ltag_type    dv_tag;

   tli_div #(
      .NW (NW),
      .DW (33),
      .QW (32),
      .TW ($bits(ltag_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_tag    (tag1_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf),
      .out_tag   (dv_tag)
   );

   logic              v2_ff;
   tli_pkg::word_type b2_ff;
   ltag_type          tag2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= dv_valid;
      end
      b2_ff   <= dv_tag.vert ? ONE_Q : tli_pkg::sat_word(dv_quo, dv_ovf, dv_tag.neg, 1'b1);
      tag2_ff <= dv_tag;
   end

   logic               v3_ff;
   logic signed [63:0] prod_ff;
   tli_pkg::word_type  b3_ff;
   ltag_type           tag3_ff;
   logic signed [63:0] prod_in;

   assign prod_in = b2_ff * tag2_ff.x2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      prod_ff <= prod_in;
      b3_ff   <= b2_ff;
      tag3_ff <= tag2_ff;
   end

   logic               v4_ff;
   tli_pkg::line_coef_type coef_ff;
   logic signed [63:0] sh, sum;
   tli_pkg::word_type  c_in;

   always_comb begin
      sh   = prod_ff >>> FRAC_BITS;
      sum  = sh + 64'(tag3_ff.y2);
      c_in = tag3_ff.vert ? clamp_coef(-64'(tag3_ff.x1)) : clamp_coef(-sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      coef_ff.b     <= b3_ff;
      coef_ff.c     <= c_in;
      coef_ff.has_y <= !tag3_ff.vert;
   end

   assign out_valid = v4_ff;
   assign out_coef  = coef_ff;

endmodule

>>> rtl/tli_meet.sv
// Solve pipeline: compares two lines and finds their crossing point.
`timescale 1ns / 1ps
module tli_meet #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tli_pkg::line_coef_type in_one,
   input  tli_pkg::line_coef_type in_two,
   input  logic [15:0]            tol,
   output logic                   out_valid,
   output logic [1:0]             out_status,
   output tli_pkg::word_type      out_x,
   output tli_pkg::word_type      out_y
);

   localparam int XNW = 33 + FRAC_BITS;

   typedef struct packed {
      logic [1:0]        status;
      logic              neg;
      logic              xuse;
      tli_pkg::word_type xb;
      tli_pkg::word_type xc;
      logic              xh;
   } ytag_type;

   typedef struct packed {
      logic              negx;
      logic              xuse;
      tli_pkg::word_type y;
      logic [1:0]        status;
   } xtag_type;

   logic [32:0] tol_w;
   assign tol_w = 33'(tol);

   // M0: differences, determinant, pick line for x
   logic               v0_ff;
   logic signed [32:0] det0_ff, db_ff, dc_ff;
   logic               aok_ff, xuse0_ff, xh0_ff;
   tli_pkg::word_type  xb0_ff, xc0_ff, b1_ff, c1_ff, b2_ff, c2_ff;
   logic               sel1, sel2, a_ok;
   logic signed [32:0] det_in;

   always_comb begin
      sel2   = (tli_pkg::mag33(33'(in_two.b)) >= tol_w) && (in_two.b != '0);
      sel1   = (tli_pkg::mag33(33'(in_one.b)) >= tol_w) && (in_one.b != '0);
      det_in = (in_one.has_y ? 33'(in_two.b) : 33'sd0)
             - (in_two.has_y ? 33'(in_one.b) : 33'sd0);
      a_ok   = (in_one.has_y == in_two.has_y) ? (tol != '0)
                                              : ((33'd1 << FRAC_BITS) < tol_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      det0_ff  <= det_in;
      db_ff    <= 33'(in_one.b) - 33'(in_two.b);
      dc_ff    <= 33'(in_one.c) - 33'(in_two.c);
      aok_ff   <= a_ok;
      xuse0_ff <= sel1 || sel2;
      xb0_ff   <= sel2 ? in_two.b : in_one.b;
      xc0_ff   <= sel2 ? in_two.c : in_one.c;
      xh0_ff   <= sel2 ? in_two.has_y : in_one.has_y;
      b1_ff    <= in_one.b;
      c1_ff    <= in_one.c;
      b2_ff    <= in_two.b;
      c2_ff    <= in_two.c;
   end

   // M1: status and cross products
   logic               v1_ff;
   logic [1:0]         st1_ff;
   logic signed [32:0] det1_ff;
   logic signed [63:0] p1_ff, p2_ff;
   logic               xuse1_ff, xh1_ff;
   tli_pkg::word_type  xb1_ff, xc1_ff;
   logic               same, single;
   logic [1:0]         st_in;
   logic signed [63:0] p1_in, p2_in;

   always_comb begin
      same   = aok_ff && (tli_pkg::mag33(db_ff) < tol_w) && (tli_pkg::mag33(dc_ff) < tol_w);
      single = (tli_pkg::mag33(det0_ff) >= tol_w) && (det0_ff != '0);
      if (same) begin
         st_in = tli_pkg::ST_SAME;
      end else if (single) begin
         st_in = tli_pkg::ST_POINT;
      end else begin
         st_in = tli_pkg::ST_PARALLEL;
      end
      p1_in = c2_ff * b1_ff;
      p2_in = c1_ff * b2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      st1_ff   <= st_in;
      det1_ff  <= det0_ff;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      xuse1_ff <= xuse0_ff;
      xh1_ff   <= xh0_ff;
      xb1_ff   <= xb0_ff;
      xc1_ff   <= xc0_ff;
   end

   // M2: numerator
   logic               v2_ff;
   logic signed [63:0] num2_ff;
   logic signed [32:0] det2_ff;
   ytag_type           t2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      num2_ff     <= p1_ff - p2_ff;
      det2_ff     <= det1_ff;
      t2_ff.status <= st1_ff;
      t2_ff.neg    <= 1'b0;
      t2_ff.xuse   <= xuse1_ff;
      t2_ff.xb     <= xb1_ff;
      t2_ff.xc     <= xc1_ff;
      t2_ff.xh     <= xh1_ff;
   end

   // M3: magnitudes into the y divider
   logic        v3_ff;
   logic [63:0] nmag_ff;
   logic [32:0] dmag_ff;
   ytag_type    t3_ff;
   ytag_type    t3_in;

   always_comb begin
      t3_in     = t2_ff;
      t3_in.neg = num2_ff[63] ^ det2_ff[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      nmag_ff <= num2_ff[63] ? 64'(-num2_ff) : 64'(num2_ff);
      dmag_ff <= tli_pkg::mag33(det2_ff);
      t3_ff   <= t3_in;
   end

   logic        yv_valid;
   logic [31:0] yv_quo;
   logic        yv_ovf;
   ytag_type    yv_tag;

   tli_div #(
      .NW (64),
      .DW (33),
      .QW (32),
      .TW ($bits(ytag_type))
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (nmag_ff),
      .in_den    (dmag_ff),
      .in_tag    (t3_ff),
      .out_valid (yv_valid),
      .out_quo   (yv_quo),
      .out_ovf   (yv_ovf),
      .out_tag   (yv_tag)
   );

   // M4: saturate y
   logic              v4_ff;
   tli_pkg::word_type y4_ff;
   ytag_type          t4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= yv_valid;
      end
      y4_ff <= (yv_tag.status == tli_pkg::ST_POINT)
             ? tli_pkg::sat_word(yv_quo, yv_ovf, yv_tag.neg, 1'b0) : '0;
      t4_ff <= yv_tag;
   end

   // M5: offset term
   logic               v5_ff;
   logic signed [32:0] tt_ff;
   tli_pkg::word_type  y5_ff;
   ytag_type           t5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      tt_ff <= (t4_ff.xh ? 33'(y4_ff) : 33'sd0) + 33'(t4_ff.xc);
      y5_ff <= y4_ff;
      t5_ff <= t4_ff;
   end

   // M6: magnitudes into the x divider
   logic           v6_ff;
   logic [XNW-1:0] xnum_ff;
   logic [31:0]    xden_ff;
   xtag_type       x6_ff;
   logic [32:0]    tmag, bmag;

   always_comb begin
      tmag = tli_pkg::mag33(tt_ff);
      bmag = tli_pkg::mag33(33'(t5_ff.xb));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      xnum_ff      <= XNW'(tmag) << FRAC_BITS;
      xden_ff      <= bmag[31:0];
      x6_ff.negx   <= !(tt_ff[32] ^ t5_ff.xb[31]);
      x6_ff.xuse   <= t5_ff.xuse;
      x6_ff.y      <= y5_ff;
      x6_ff.status <= t5_ff.status;
   end

   logic        xv_valid;
   logic [31:0] xv_quo;
   logic        xv_ovf;
   xtag_type    xv_tag;

   tli_div #(
      .NW (XNW),
      .DW (32),
      .QW (32),
      .TW ($bits(xtag_type))
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    (xnum_ff),
      .in_den    (xden_ff),
      .in_tag    (x6_ff),
      .out_valid (xv_valid),
      .out_quo   (xv_quo),
      .out_ovf   (xv_ovf),
      .out_tag   (xv_tag)
   );

   // M7: result word
   logic              v7_ff;
   logic [1:0]        st7_ff;
   tli_pkg::word_type x7_ff, y7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= xv_valid;
      end
      st7_ff <= xv_tag.status;
      y7_ff  <= xv_tag.y;
      x7_ff  <= ((xv_tag.status == tli_pkg::ST_POINT) && xv_tag.xuse)
              ? tli_pkg::sat_word(xv_quo, xv_ovf, xv_tag.negx, 1'b0) : '0;
   end

   assign out_valid  = v7_ff;
   assign out_status = st7_ff;
   assign out_x      = x7_ff;
   assign out_y      = y7_ff;

endmodule

>>> rtl/two_line_intersection_top.sv
// Top level of the two-line intersection pipeline.
//
//   channel  ports                         handshake
//   req      req_line_*                    start, busy (busy held low)
//   csr      csr_tolerance                 csr_valid, csr_ready (ready held high)
//   rsp      rsp_meet_status/_x/_y         rsp_valid, one-cycle strobe
//
// One word accepted every cycle; results strobe on rsp_valid in order of acceptance.
// The path runs through three chained 32-stage restoring dividers (slope, one per line; y; x).
// Synchronous reset clears all valid bits and loads tolerance with 1.
// The receiver cannot stall, so the pipeline always advances.
`timescale 1ns / 1ps
module two_line_intersection_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tli_pkg::word_type req_line_one_ax,
   input  tli_pkg::word_type req_line_one_ay,
   input  tli_pkg::word_type req_line_one_bx,
   input  tli_pkg::word_type req_line_one_by,
   input  tli_pkg::word_type req_line_two_ax,
   input  tli_pkg::word_type req_line_two_ay,
   input  tli_pkg::word_type req_line_two_bx,
   input  tli_pkg::word_type req_line_two_by,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_tolerance,
   output logic              rsp_valid,
   output logic [1:0]        rsp_meet_status,
   output tli_pkg::word_type rsp_meet_x,
   output tli_pkg::word_type rsp_meet_y
);

   logic [15:0] tol_ff;
   logic        req_take;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign req_take  = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tli_pkg::TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_tolerance;
      end
   end

   logic                   one_valid, two_valid;
   tli_pkg::line_coef_type one_coef, two_coef;

   tli_line #(.FRAC_BITS (FRAC_BITS)) u_line_one (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_x1     (req_line_one_ax),
      .in_y1     (req_line_one_ay),
      .in_x2     (req_line_one_bx),
      .in_y2     (req_line_one_by),
      .tol       (tol_ff),
      .out_valid (one_valid),
      .out_coef  (one_coef)
   );

   tli_line #(.FRAC_BITS (FRAC_BITS)) u_line_two (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_x1     (req_line_two_ax),
      .in_y1     (req_line_two_ay),
      .in_x2     (req_line_two_bx),
      .in_y2     (req_line_two_by),
      .tol       (tol_ff),
      .out_valid (two_valid),
      .out_coef  (two_coef)
   );

   tli_meet #(.FRAC_BITS (FRAC_BITS)) u_meet (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (one_valid && two_valid),
      .in_one     (one_coef),
      .in_two     (two_coef),
      .tol        (tol_ff),
      .out_valid  (rsp_valid),
      .out_status (rsp_meet_status),
      .out_x      (rsp_meet_x),
      .out_y      (rsp_meet_y)
   );

endmodule

>>> rtl/tli_checker.sv
// Port-level checks of the intersection block and their binding.
`timescale 1ns / 1ps
`include "two_line_intersection_top_macros.svh"
module tli_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input logic [1:0]        rsp_meet_status,
   input tli_pkg::word_type rsp_meet_x,
   input tli_pkg::word_type rsp_meet_y
);

   logic status_ok;
   logic point_clear;

   assign status_ok   = (rsp_meet_status == tli_pkg::ST_PARALLEL)
                     || (rsp_meet_status == tli_pkg::ST_POINT)
                     || (rsp_meet_status == tli_pkg::ST_SAME);
   assign point_clear = (rsp_meet_x == '0) && (rsp_meet_y == '0);

   `TLI_CHECK(a_never_busy, !busy, "busy raised")
   `TLI_CHECK(a_status_code, rsp_valid |-> status_ok, "bad status word")
   `TLI_CHECK(a_zero_point, (rsp_valid && rsp_meet_status != tli_pkg::ST_POINT) |-> point_clear, "point set without single crossing")
   `TLI_CHECK_ANY(a_quiet_after_reset, $past(reset) |-> !rsp_valid, "result strobe right after reset")

endmodule

bind two_line_intersection_top tli_checker u_tli_checker (.*);
